// File: sv/dspwm_pkg.sv
// ----------------------------------------------------------------------------
// dspwm_pkg
// Shared types and constants of the dual software PWM with tick dividers.
// ----------------------------------------------------------------------------
package dspwm_pkg;

    localparam logic [7:0] PWM_TOP   = 8'd100;
    localparam logic [7:0] MID_CYCLE = 8'd8;
    localparam logic [3:0] STAGE_TOP = 4'd10;
    localparam logic [3:0] STAGE_RELOAD = 4'd1;

    typedef enum logic [1:0] {
        KIND_TICK        = 2'd0,
        KIND_LOAD_FIRST  = 2'd1,
        KIND_LOAD_SECOND = 2'd2
    } kind_t;

    typedef enum logic [0:0] {
        CFG_CHANNEL_A = 1'b0,
        CFG_CHANNEL_B = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  duty_a;
        logic [7:0]  duty_b;
        logic [15:0] load_value;
    } in_item_t;

    typedef struct packed {
        logic        switch_a;
        logic        switch_b;
        logic        check_window_a;
        logic        check_window_b;
        logic        mid_cycle_a;
        logic        mid_cycle_b;
        logic        load_clear;
        logic [2:0]  stage_pulses;
        logic [15:0] first_countdown;
        logic [15:0] second_countdown;
        logic [7:0]  tick_tally;
    } out_item_t;

    typedef struct packed {
        logic switch_level;
        logic check_window;
        logic mid_cycle;
        logic load_clear;
    } chan_res_t;

    typedef struct packed {
        logic [2:0]  stage_pulses;
        logic [15:0] first_countdown;
        logic [15:0] second_countdown;
        logic [7:0]  tick_tally;
    } div_res_t;

    typedef struct packed {
        logic tick;
        logic load_first;
        logic load_second;
    } div_ctrl_t;

endpackage

// File: sv/dspwm_channel.sv
// ----------------------------------------------------------------------------
// dspwm_channel
// One software PWM channel: cycle counter, switch level and check window.
// ----------------------------------------------------------------------------
module dspwm_channel
    import dspwm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic       active,
    input  logic [7:0] duty,
    output chan_res_t  res
);

    logic [7:0] cycle_reg;
    logic [7:0] cycle_next;
    logic       switch_reg;
    logic       switch_next;
    logic       window_reg;
    logic       window_next;
    logic [7:0] cycle_step;
    logic [8:0] cycle_plus_one;

    always_comb
    begin
        cycle_step     = (cycle_reg < PWM_TOP) ? cycle_reg + 8'd1 : 8'd0;
        cycle_plus_one = {1'b0, cycle_step} + 9'd1;
        cycle_next     = cycle_reg;
        switch_next    = switch_reg;
        window_next    = window_reg;
        res            = '0;
        if (active)
        begin
            if (duty == 8'd0)
            begin
                cycle_next     = 8'd0;
                switch_next    = 1'b0;
                window_next    = 1'b0;
                res.load_clear = 1'b1;
            end
            else
            begin
                cycle_next    = cycle_step;
                switch_next   = cycle_step < duty;
                window_next   = (cycle_step > 8'd1) && (cycle_plus_one < {1'b0, duty});
                res.mid_cycle = cycle_step == MID_CYCLE;
            end
        end
        res.switch_level = switch_next;
        res.check_window = window_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_reg  <= 8'd0;
            switch_reg <= 1'b0;
            window_reg <= 1'b0;
        end
        else if (advance)
        begin
            cycle_reg  <= cycle_next;
            switch_reg <= switch_next;
            window_reg <= window_next;
        end
    end

endmodule

// File: sv/dspwm_divider.sv
// ----------------------------------------------------------------------------
// dspwm_divider
// Three cascaded divide-by-ten stages, two countdown timers and a tick tally.
// ----------------------------------------------------------------------------
module dspwm_divider
    import dspwm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  div_ctrl_t   ctrl,
    input  logic [15:0] load_value,
    output div_res_t    res
);

    logic [3:0]  stage_one_reg;
    logic [3:0]  stage_one_next;
    logic [3:0]  stage_two_reg;
    logic [3:0]  stage_two_next;
    logic [3:0]  stage_three_reg;
    logic [3:0]  stage_three_next;
    logic [15:0] first_reg;
    logic [15:0] first_next;
    logic [15:0] second_reg;
    logic [15:0] second_next;
    logic [7:0]  tally_reg;
    logic [7:0]  tally_next;
    logic [2:0]  wrap;

    always_comb
    begin
        stage_one_next   = stage_one_reg;
        stage_two_next   = stage_two_reg;
        stage_three_next = stage_three_reg;
        first_next       = first_reg;
        second_next      = second_reg;
        tally_next       = tally_reg;
        wrap             = 3'b000;
        if (ctrl.tick)
        begin
            tally_next = tally_reg + 8'd1;
            if (stage_one_reg < STAGE_TOP)
            begin
                stage_one_next = stage_one_reg + 4'd1;
            end
            else
            begin
                stage_one_next = STAGE_RELOAD;
                wrap[0]        = 1'b1;
                if (stage_two_reg < STAGE_TOP)
                begin
                    stage_two_next = stage_two_reg + 4'd1;
                end
                else
                begin
                    stage_two_next = STAGE_RELOAD;
                    wrap[1]        = 1'b1;
                    if (stage_three_reg < STAGE_TOP)
                    begin
                        stage_three_next = stage_three_reg + 4'd1;
                    end
                    else
                    begin
                        stage_three_next = STAGE_RELOAD;
                        wrap[2]          = 1'b1;
                        if (first_reg != 16'd0)
                        begin
                            first_next = first_reg - 16'd1;
                        end
                        if (second_reg != 16'd0)
                        begin
                            second_next = second_reg - 16'd1;
                        end
                    end
                end
            end
        end
        else if (ctrl.load_first)
        begin
            first_next = load_value;
        end
        else if (ctrl.load_second)
        begin
            second_next = load_value;
        end
        res.stage_pulses     = wrap;
        res.first_countdown  = first_next;
        res.second_countdown = second_next;
        res.tick_tally       = tally_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_one_reg   <= 4'd0;
            stage_two_reg   <= 4'd0;
            stage_three_reg <= 4'd0;
            first_reg       <= 16'd0;
            second_reg      <= 16'd0;
            tally_reg       <= 8'd0;
        end
        else if (advance)
        begin
            stage_one_reg   <= stage_one_next;
            stage_two_reg   <= stage_two_next;
            stage_three_reg <= stage_three_next;
            first_reg       <= first_next;
            second_reg      <= second_next;
            tally_reg       <= tally_next;
        end
    end

endmodule

// File: sv/dual_soft_pwm_with_tick_dividers.sv
// ----------------------------------------------------------------------------
// dual_soft_pwm_with_tick_dividers
// Two software PWM channels and a cascaded decimal tick divider with timers.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// cfg       in         cfg_we             cfg_index, cfg_data
// in        in         in_valid/in_ready  in_item (in_item_t)
// out       out        out_valid/out_ready out_item (out_item_t)
//
// One transfer in per cycle while the output is not stalled; an input transfer
// lands in the input register and its result is loaded into the result register
// once the output is free, which raises out_valid.
// Reset clears all counters, levels, timers and both enables.
// A stalled output holds the result; the input register still takes a new
// transfer as soon as its item moves on to the result register.
// ----------------------------------------------------------------------------
module dual_soft_pwm_with_tick_dividers
    import dspwm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic      cfg_data,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic      enable_a_reg;
    logic      enable_b_reg;
    logic      stage_valid_reg;
    in_item_t  stage_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    logic      advance;
    logic      is_tick;
    div_ctrl_t div_ctrl;
    chan_res_t res_a;
    chan_res_t res_b;
    div_res_t  res_div;

    assign advance  = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || advance;
    assign is_tick  = stage_item_reg.kind == KIND_TICK;

    always_comb
    begin
        div_ctrl.tick        = is_tick;
        div_ctrl.load_first  = stage_item_reg.kind == KIND_LOAD_FIRST;
        div_ctrl.load_second = stage_item_reg.kind == KIND_LOAD_SECOND;
    end

    dspwm_channel u_channel_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .active  (is_tick && enable_a_reg),
        .duty    (stage_item_reg.duty_a),
        .res     (res_a)
    );

    dspwm_channel u_channel_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .active  (is_tick && enable_b_reg),
        .duty    (stage_item_reg.duty_b),
        .res     (res_b)
    );

    dspwm_divider u_divider (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .ctrl       (div_ctrl),
        .load_value (stage_item_reg.load_value),
        .res        (res_div)
    );

    always_comb
    begin
        out_item_next.switch_a         = res_a.switch_level;
        out_item_next.switch_b         = res_b.switch_level;
        out_item_next.check_window_a   = res_a.check_window;
        out_item_next.check_window_b   = res_b.check_window;
        out_item_next.mid_cycle_a      = res_a.mid_cycle;
        out_item_next.mid_cycle_b      = res_b.mid_cycle;
        out_item_next.load_clear       = res_a.load_clear || res_b.load_clear;
        out_item_next.stage_pulses     = res_div.stage_pulses;
        out_item_next.first_countdown  = res_div.first_countdown;
        out_item_next.second_countdown = res_div.second_countdown;
        out_item_next.tick_tally       = res_div.tick_tally;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_a_reg <= 1'b0;
            enable_b_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CHANNEL_A: enable_a_reg <= cfg_data;
                CFG_CHANNEL_B: enable_b_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                stage_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_item_reg <= in_item;
        end
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
